// ===== src/framebuffer_update_rect_planner_macros.svh =====
// Assertion helpers shared by the checking code of the update planner.
// Both macros sample on clk and are switched off while rst is high.
`ifndef FRAMEBUFFER_UPDATE_RECT_PLANNER_MACROS_SVH
`define FRAMEBUFFER_UPDATE_RECT_PLANNER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FBUR_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define FBUR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

`endif

// ===== src/fbur_pkg.sv =====
package fbur_pkg;

  localparam int MAX_RECTS = 7;
  localparam int CNT_W = 3;
  localparam int IN_DATA_W = 224;
  localparam int IN_USER_W = 2;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 3;

  localparam logic ENC_RAW = 1'b0;
  localparam logic ENC_COPY = 1'b1;

  typedef enum logic [1:0] {
    KIND_DAMAGE = 2'd0,
    KIND_OLD_CURSOR = 2'd1,
    KIND_NEW_CURSOR = 2'd2
  } rect_kind_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } rect_t;

  typedef struct packed {
    rect_t rect;
    logic enc;
    rect_kind_t kind;
  } entry_t;

  typedef struct packed {
    entry_t [MAX_RECTS-1:0] ent;
    logic [CNT_W-1:0] count;
    logic [31:0] copy_src;
    rect_t cur;
  } plan_t;

endpackage

// ===== src/fbur_plan.sv =====
module fbur_plan #(
  parameter int COORD_BITS = 16
) (
  input fbur_pkg::rect_t damage_rect,
  input fbur_pkg::rect_t cursor_rect,
  input fbur_pkg::rect_t motion_rect,
  input fbur_pkg::rect_t prev_cursor,
  input logic cursor_changed,
  input logic motion_found,
  input logic [31:0] motion_source,
  output fbur_pkg::plan_t plan
);
  import fbur_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EB = COORD_BITS + 1;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
  } box_t;

  function automatic box_t unpack(input rect_t r);
    box_t b;
    b.x = r.x[CB-1:0];
    b.y = r.y[CB-1:0];
    b.w = r.w[CB-1:0];
    b.h = r.h[CB-1:0];
    return b;
  endfunction

  function automatic rect_t pack(input box_t b);
    rect_t r;
    r.x = 16'(b.x);
    r.y = 16'(b.y);
    r.w = 16'(b.w);
    r.h = 16'(b.h);
    return r;
  endfunction

  function automatic logic [EB-1:0] esum(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return EB'(a) + EB'(b);
  endfunction

  function automatic logic nonempty(input box_t b);
    return (b.w != '0) && (b.h != '0);
  endfunction

  function automatic logic within_box(input box_t a, input box_t c);
    return (a.x >= c.x) && (a.y >= c.y) && (esum(a.x, a.w) <= esum(c.x, c.w)) &&
           (esum(a.y, a.h) <= esum(c.y, c.h));
  endfunction

  function automatic logic disjoint(input box_t a, input box_t b);
    return !nonempty(a) || !nonempty(b) || (EB'(a.x) >= esum(b.x, b.w)) ||
           (EB'(a.y) >= esum(b.y, b.h)) || (esum(a.x, a.w) <= EB'(b.x)) ||
           (esum(a.y, a.h) <= EB'(b.y));
  endfunction

  function automatic logic [CB-1:0] sat(input logic [EB-1:0] v);
    return (v > EB'(CMAX)) ? CMAX : v[CB-1:0];
  endfunction

  function automatic rect_t mk(input logic [EB-1:0] x, input logic [EB-1:0] y,
                               input logic [EB-1:0] w, input logic [EB-1:0] h);
    box_t b;
    b.x = sat(x);
    b.y = sat(y);
    b.w = sat(w);
    b.h = sat(h);
    return pack(b);
  endfunction

  box_t dmg, cur, mot, old;
  logic chg, put_cur, put_dmg, put_old, use_motion;
  logic [EB-1:0] mb, db, mr, dr;
  entry_t [MAX_RECTS-1:0] cand;
  logic [MAX_RECTS-1:0] en;
  logic [CNT_W-1:0] pos;

  assign dmg = unpack(damage_rect);
  assign cur = unpack(cursor_rect);
  assign mot = unpack(motion_rect);
  assign old = unpack(prev_cursor);

  // A cursor that moved counts as changed even if its image did not.
  assign chg = cursor_changed || (cur.x != old.x) || (cur.y != old.y);
  assign put_cur = nonempty(cur) && (chg || !disjoint(dmg, cur));
  assign put_dmg = nonempty(dmg) && (!put_cur || !within_box(dmg, cur));
  assign put_old = nonempty(old) && chg && (!put_dmg || !within_box(old, dmg)) &&
                   (!put_cur || !within_box(old, cur));
  assign use_motion = put_dmg && motion_found;

  assign mb = esum(mot.y, mot.h);
  assign db = esum(dmg.y, dmg.h);
  assign mr = esum(mot.x, mot.w);
  assign dr = esum(dmg.x, dmg.w);

  always_comb begin
    cand[0].rect = motion_found ? pack(mot) : pack(dmg);
    cand[0].enc = motion_found ? ENC_COPY : ENC_RAW;
    cand[0].kind = KIND_DAMAGE;
    cand[1].rect = mk(EB'(dmg.x), EB'(dmg.y), EB'(dmg.w), EB'(mot.y - dmg.y));
    cand[2].rect = mk(EB'(dmg.x), mb, EB'(dmg.w), db - mb);
    cand[3].rect = mk(EB'(dmg.x), EB'(mot.y), EB'(mot.x - dmg.x), EB'(mot.h));
    cand[4].rect = mk(mr, EB'(mot.y), dr - mr, EB'(mot.h));
    for (int k = 1; k < 5; k++) begin
      cand[k].enc = ENC_RAW;
      cand[k].kind = KIND_DAMAGE;
    end
    cand[5].rect = pack(old);
    cand[5].enc = ENC_RAW;
    cand[5].kind = KIND_OLD_CURSOR;
    cand[6].rect = pack(cur);
    cand[6].enc = ENC_RAW;
    cand[6].kind = KIND_NEW_CURSOR;

    en[0] = put_dmg;
    en[1] = use_motion && (mot.y > dmg.y);
    en[2] = use_motion && (mb < db);
    en[3] = use_motion && (mot.x > dmg.x);
    en[4] = use_motion && (mr < dr);
    en[5] = put_old;
    en[6] = put_cur;
  end

  // Pack the enabled candidates to the front, keeping their order.
  always_comb begin
    pos = '0;
    plan.ent = '0;
    for (int k = 0; k < MAX_RECTS; k++) begin
      if (en[k]) begin
        plan.ent[pos] = cand[k];
        pos = pos + CNT_W'(1);
      end
    end
    plan.count = pos;
    plan.copy_src = {16'(motion_source[16 +: CB]), 16'(motion_source[0 +: CB])};
    plan.cur = pack(cur);
  end

endmodule

// ===== src/fbur_queue.sv =====
module fbur_queue (
  input logic clk,
  input logic rst,
  input logic load,
  input fbur_pkg::plan_t plan,
  input logic m_tready,
  output logic m_tvalid,
  output fbur_pkg::entry_t head,
  output logic [fbur_pkg::CNT_W-1:0] rect_total,
  output logic [31:0] copy_src,
  output logic last,
  output logic can_load
);
  import fbur_pkg::*;

  entry_t [MAX_RECTS-1:0] ent;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] total;
  logic [31:0] src;
  logic fire;

  assign m_tvalid = (rem != '0);
  assign fire = m_tvalid && m_tready;
  assign head = ent[0];
  assign rect_total = total;
  assign copy_src = src;
  assign last = (rem == CNT_W'(1));
  // Room for a new list when empty or when the final beat leaves this cycle.
  assign can_load = (rem == '0) || (last && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= plan.count;
    end else if (fire) begin
      rem <= rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= plan.ent;
      total <= plan.count;
      src <= plan.copy_src;
    end else if (fire) begin
      ent <= {entry_t'('0), ent[MAX_RECTS-1:1]};
    end
  end

endmodule

// ===== src/framebuffer_update_rect_planner.sv =====
// Update-rectangle planner for a remote-framebuffer server. Each input beat
// carries one update request; the block answers with the rectangle list of
// one update message, one rectangle per output beat, with tlast on the final
// one, or with no beat at all when nothing needs sending. The sustained rate
// is set by the output shift list, which emits one rectangle per cycle while
// m_tready is high. The first rectangle of a request comes out of the list
// register after the request has passed the input register. A new request
// is taken while the previous list is still draining and is planned as
// soon as the last beat of that list leaves. The previous cursor rectangle
// is held internally and reset to "no cursor".
module framebuffer_update_rect_planner #(
  parameter int COORD_BITS = 16
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0 up: damage_rect[63:0], cursor_rect[127:64],
  // motion_rect[191:128], motion_source[223:192].
  input logic [fbur_pkg::IN_DATA_W-1:0] s_tdata,
  // Fields from bit 0 up: cursor_changed[0], motion_found[1].
  input logic [fbur_pkg::IN_USER_W-1:0] s_tuser,
  output logic m_tvalid,
  input logic m_tready,
  // Fields from bit 0 up: rect[63:0], copy_source[95:64], rect_total[98:96],
  // zero fill[103:99].
  output logic [fbur_pkg::OUT_DATA_W-1:0] m_tdata,
  // Fields from bit 0 up: encoding[0], rect_kind[2:1].
  output logic [fbur_pkg::OUT_USER_W-1:0] m_tuser,
  output logic m_tlast
);
  import fbur_pkg::*;

  // Input register: holds one request until the list register can take
  // its plan.
  logic in_valid;
  logic [IN_DATA_W-1:0] in_data;
  logic [IN_USER_W-1:0] in_user;

  // Cursor rectangle of the last planned request, already masked.
  rect_t prev_cursor;

  plan_t plan;
  logic advance;
  logic can_load;
  entry_t head;
  logic [CNT_W-1:0] rect_total;
  logic [31:0] copy_src;
  logic last;

  assign s_tready = !in_valid || can_load;
  assign advance = in_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_user <= s_tuser;
    end
  end

  // The cursor state advances with every planned request, including those
  // that produce no rectangles.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cursor <= '0;
    end else if (advance) begin
      prev_cursor <= plan.cur;
    end
  end

  // All decisions, strip splitting and list packing happen in one pass of
  // combinational logic between the input register and the list register.
  fbur_plan #(
    .COORD_BITS(COORD_BITS)
  ) u_plan (
    .damage_rect(rect_t'(in_data[63:0])),
    .cursor_rect(rect_t'(in_data[127:64])),
    .motion_rect(rect_t'(in_data[191:128])),
    .prev_cursor(prev_cursor),
    .cursor_changed(in_user[0]),
    .motion_found(in_user[1]),
    .motion_source(in_data[223:192]),
    .plan(plan)
  );

  // The list register shifts one rectangle out per accepted output beat.
  fbur_queue u_queue (
    .clk(clk),
    .rst(rst),
    .load(advance && (plan.count != '0)),
    .plan(plan),
    .m_tready(m_tready),
    .m_tvalid(m_tvalid),
    .head(head),
    .rect_total(rect_total),
    .copy_src(copy_src),
    .last(last),
    .can_load(can_load)
  );

  // Only the copy rectangle carries a source point; every other beat shows
  // zero there.
  assign m_tdata = {5'b0, rect_total, (head.enc == ENC_COPY) ? copy_src : 32'b0, head.rect};
  assign m_tuser = {head.kind, head.enc};
  assign m_tlast = last;

endmodule

// ===== src/fbur_checker.sv =====
`include "framebuffer_update_rect_planner_macros.svh"

module fbur_checker (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [fbur_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [fbur_pkg::OUT_USER_W-1:0] m_tuser,
  input logic m_tlast
);
  import fbur_pkg::*;

  // A stalled output beat keeps its contents.
  `FBUR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // Within one update the next beat follows at once with the same count.
  `FBUR_ASSERT_NEXT(a_list_runs_on, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[98:96] == $past(m_tdata[98:96])))

  // Raw rectangles show no source point.
  `FBUR_ASSERT_SAME(a_raw_no_source, m_tvalid && (m_tuser[0] == ENC_RAW), m_tdata[95:64] == 32'b0)

  // Only a damage part can be sent as a copy.
  `FBUR_ASSERT_SAME(a_copy_is_damage, m_tvalid && (m_tuser[0] == ENC_COPY), m_tuser[2:1] == KIND_DAMAGE)

endmodule

bind framebuffer_update_rect_planner fbur_checker u_fbur_checker (.*);

// ===== bench/testbench.sv =====
// Self-checking bench for the update-rectangle planner. Every request beat
// that the block accepts is planned again here, and the rectangle beats that
// it should cause are queued in order. Each output beat is checked against
// the oldest queued beat.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fbur_pkg::*;

  localparam int COORD_BITS = 16;
  localparam logic [31:0] COORD_MAX = (32'd1 << COORD_BITS) - 32'd1;
  // The first rectangle leaves through the input register, then the list register.
  localparam int LATENCY = 2;
  // The worst case is about 130 requests of seven beats each, every beat
  // held up by output stall, plus input gaps. Far less than this limit is
  // ever needed.
  localparam int CYCLE_LIMIT = 200000;

  // Rectangle with room for the 17-bit edge sums.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] w;
    logic [31:0] h;
  } box_t;

  // One update request, as it travels on the input side.
  typedef struct packed {
    logic [31:0] source;
    logic [63:0] motion;
    logic [63:0] cursor;
    logic [63:0] damage;
    logic moved;
    logic changed;
  } request_t;

  // One rectangle beat of an update message.
  typedef struct packed {
    rect_t rect;
    logic enc;
    logic [31:0] src;
    rect_kind_t kind;
    logic [CNT_W-1:0] total;
    logic last;
  } rect_beat_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  // Fields from bit 0 up: damage_rect[63:0], cursor_rect[127:64],
  // motion_rect[191:128], motion_source[223:192].
  logic [IN_DATA_W-1:0] s_tdata;
  // Fields from bit 0 up: cursor_changed[0], motion_found[1].
  logic [IN_USER_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  // Fields from bit 0 up: rect[63:0], copy_source[95:64], rect_total[98:96],
  // zero fill[103:99].
  logic [OUT_DATA_W-1:0] m_tdata;
  // Fields from bit 0 up: encoding[0], rect_kind[2:1].
  logic [OUT_USER_W-1:0] m_tuser;
  logic m_tlast;

  // Rectangle beats still owed by the block, oldest first.
  rect_beat_t planned_beats[$];
  // Our copy of the cursor rectangle that the block remembers.
  logic [63:0] cursor_seen;
  int errors;
  int cycle_count;
  // When clear, neither side idles nor stalls.
  bit idle_on;

  framebuffer_update_rect_planner #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Planning of one update, kept in the block's own terms.
  // ---------------------------------------------------------------------

  function automatic box_t unpack_box(logic [63:0] v);
    box_t b;
    b.x = {16'd0, v[63:48]} & COORD_MAX;
    b.y = {16'd0, v[47:32]} & COORD_MAX;
    b.w = {16'd0, v[31:16]} & COORD_MAX;
    b.h = {16'd0, v[15:0]} & COORD_MAX;
    return b;
  endfunction

  function automatic rect_t pack_box(box_t b);
    return rect_t'({b.x[15:0], b.y[15:0], b.w[15:0], b.h[15:0]});
  endfunction

  function automatic bit has_area(box_t b);
    return b.w != 0 && b.h != 0;
  endfunction

  function automatic bit covered_by(box_t a, box_t c);
    return a.x >= c.x && a.y >= c.y && a.x + a.w <= c.x + c.w &&
           a.y + a.h <= c.y + c.h;
  endfunction

  function automatic bit apart(box_t a, box_t b);
    return !has_area(a) || !has_area(b) || a.x >= b.x + b.w ||
           a.y >= b.y + b.h || a.x + a.w <= b.x || a.y + a.h <= b.y;
  endfunction

  function automatic logic [31:0] clamp(logic [31:0] v);
    return v > COORD_MAX ? COORD_MAX : v;
  endfunction

  // A raw strip; any edge beyond the coordinate range saturates.
  function automatic box_t strip(logic [31:0] x, logic [31:0] y,
                                 logic [31:0] w, logic [31:0] h);
    box_t b;
    b.x = clamp(x);
    b.y = clamp(y);
    b.w = clamp(w);
    b.h = clamp(h);
    return b;
  endfunction

  // Works out the rectangle list that one accepted request causes and
  // queues it, then remembers the new cursor.
  task automatic plan_update(request_t r);
    box_t dmg, cur, old, mot;
    box_t parts[MAX_RECTS];
    rect_kind_t kinds[MAX_RECTS];
    logic [31:0] sx, sy, mb, db, mr, dr;
    bit chg, send_cur, send_dmg, send_old, copy_first;
    rect_beat_t b;
    int n;
    dmg = unpack_box(r.damage);
    cur = unpack_box(r.cursor);
    old = unpack_box(cursor_seen);
    mot = unpack_box(r.motion);
    sx = {16'd0, r.source[31:16]} & COORD_MAX;
    sy = {16'd0, r.source[15:0]} & COORD_MAX;
    n = 0;
    copy_first = 1'b0;

    // A cursor that moved counts as changed even with the same image.
    chg = r.changed || cur.x != old.x || cur.y != old.y;
    send_cur = has_area(cur) && (chg || !apart(dmg, cur));
    send_dmg = has_area(dmg) && (!send_cur || !covered_by(dmg, cur));
    send_old = has_area(old) && chg && (!send_dmg || !covered_by(old, dmg)) &&
               (!send_cur || !covered_by(old, cur));

    if (send_dmg) begin
      if (r.moved) begin
        // Copy rectangle first, then the raw strips around it.
        mb = mot.y + mot.h;
        db = dmg.y + dmg.h;
        mr = mot.x + mot.w;
        dr = dmg.x + dmg.w;
        copy_first = 1'b1;
        kinds[n] = KIND_DAMAGE;
        parts[n] = mot;
        n = n + 1;
        if (mot.y > dmg.y) begin
          kinds[n] = KIND_DAMAGE;
          parts[n] = strip(dmg.x, dmg.y, dmg.w, mot.y - dmg.y);
          n = n + 1;
        end
        if (mb < db) begin
          kinds[n] = KIND_DAMAGE;
          parts[n] = strip(dmg.x, mb, dmg.w, db - mb);
          n = n + 1;
        end
        if (mot.x > dmg.x) begin
          kinds[n] = KIND_DAMAGE;
          parts[n] = strip(dmg.x, mot.y, mot.x - dmg.x, mot.h);
          n = n + 1;
        end
        if (mr < dr) begin
          kinds[n] = KIND_DAMAGE;
          parts[n] = strip(mr, mot.y, dr - mr, mot.h);
          n = n + 1;
        end
      end else begin
        kinds[n] = KIND_DAMAGE;
        parts[n] = dmg;
        n = n + 1;
      end
    end
    if (send_old) begin
      kinds[n] = KIND_OLD_CURSOR;
      parts[n] = old;
      n = n + 1;
    end
    if (send_cur) begin
      kinds[n] = KIND_NEW_CURSOR;
      parts[n] = cur;
      n = n + 1;
    end

    for (int i = 0; i < n; i++) begin
      b.rect = pack_box(parts[i]);
      b.enc = (i == 0 && copy_first) ? ENC_COPY : ENC_RAW;
      b.src = (b.enc == ENC_COPY) ? {sx[15:0], sy[15:0]} : 32'd0;
      b.kind = kinds[i];
      b.total = n[CNT_W-1:0];
      b.last = (i == n - 1);
      planned_beats.push_back(b);
    end
    cursor_seen = pack_box(cur);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  function automatic logic [63:0] rect_bits(logic [15:0] x, logic [15:0] y,
                                            logic [15:0] w, logic [15:0] h);
    return {x, y, w, h};
  endfunction

  function automatic request_t request_of(logic [63:0] damage, logic [63:0] cursor,
                                          logic changed, logic moved,
                                          logic [63:0] motion, logic [31:0] source);
    request_t r;
    r.damage = damage;
    r.cursor = cursor;
    r.changed = changed;
    r.moved = moved;
    r.motion = motion;
    r.source = source;
    return r;
  endfunction

  // Mostly small positions, now and then right at the top of the range.
  function automatic logic [15:0] rand_coord();
    if ($urandom_range(99) < 12) return 16'($urandom_range(16'hFF00, 16'hFFFF));
    return 16'($urandom_range(0, 1023));
  endfunction

  function automatic logic [15:0] rand_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) return 16'd0;
    if (pick < 16) return 16'($urandom_range(16'h8000, 16'hFFFF));
    return 16'($urandom_range(1, 128));
  endfunction

  // A well-formed request: the cursor often stays put, and the motion
  // rectangle usually lies inside the damage. With noise set, every field
  // is random bits.
  function automatic request_t random_request(bit noise);
    request_t r;
    logic [31:0] dx, dy, dw, dh, mw, mh;
    int pick;
    if (noise) begin
      r.damage = {$urandom, $urandom};
      r.cursor = {$urandom, $urandom};
      r.motion = {$urandom, $urandom};
      r.source = $urandom;
      r.changed = 1'($urandom_range(1));
      r.moved = 1'($urandom_range(1));
      return r;
    end
    dx = 32'(rand_coord());
    dy = 32'(rand_coord());
    dw = 32'(rand_size());
    dh = 32'(rand_size());
    r.damage = rect_bits(dx[15:0], dy[15:0], dw[15:0], dh[15:0]);
    pick = $urandom_range(99);
    if (pick < 50) begin
      r.cursor = cursor_seen;
    end else if (pick < 65) begin
      r.cursor = 64'd0;
    end else begin
      r.cursor = rect_bits(16'(dx + $urandom_range(0, 64)), 16'(dy + $urandom_range(0, 64)),
                           16'($urandom_range(0, 32)), 16'($urandom_range(0, 32)));
    end
    r.changed = ($urandom_range(99) < 30);
    r.moved = ($urandom_range(99) < 50);
    if ($urandom_range(99) < 15) begin
      r.motion = {$urandom, $urandom};
    end else begin
      mw = $urandom_range(0, dw);
      mh = $urandom_range(0, dh);
      r.motion = rect_bits(16'(dx + $urandom_range(0, dw - mw)),
                           16'(dy + $urandom_range(0, dh - mh)), mw[15:0], mh[15:0]);
    end
    r.source = $urandom;
    return r;
  endfunction

  // Offers one request beat, with a random gap before it, and plans it at
  // the edge where it is taken. Valid stays high afterwards, so the next
  // call either lowers it for a gap or replaces the data directly.
  task automatic send_request(request_t r);
    if (idle_on && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {r.source, r.motion, r.cursor, r.damage};
    s_tuser <= {r.moved, r.changed};
    do @(posedge clk); while (!s_tready);
    plan_update(r);
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  task automatic test_directed_cases();
    // Nothing at all: no beat comes out.
    send_request(request_of(64'd0, 64'd0, 1'b0, 1'b0, 64'd0, 32'd0));
    // Plain damage with no cursor.
    send_request(request_of(rect_bits(10, 20, 30, 40), 64'd0, 1'b0, 1'b0, 64'd0, 32'd0));
    // A cursor that appears counts as moved, so it is sent alone.
    send_request(request_of(64'd0, rect_bits(100, 100, 16, 16), 1'b0, 1'b0, 64'd0, 32'd0));
    // Still cursor, damage away from it: damage only.
    send_request(request_of(rect_bits(0, 0, 8, 8), rect_bits(100, 100, 16, 16),
                            1'b0, 1'b0, 64'd0, 32'd0));
    // Still cursor overlapped by damage: damage and cursor.
    send_request(request_of(rect_bits(90, 90, 20, 20), rect_bits(100, 100, 16, 16),
                            1'b0, 1'b0, 64'd0, 32'd0));
    // Damage that lies inside the cursor is covered by the cursor.
    send_request(request_of(rect_bits(102, 102, 4, 4), rect_bits(100, 100, 16, 16),
                            1'b0, 1'b0, 64'd0, 32'd0));
    // Changed image in place: the old area is covered by the new cursor.
    send_request(request_of(64'd0, rect_bits(100, 100, 16, 16), 1'b1, 1'b0, 64'd0, 32'd0));
    // The cursor moves: old area and new cursor.
    send_request(request_of(64'd0, rect_bits(200, 200, 16, 16), 1'b0, 1'b0, 64'd0, 32'd0));
    // The cursor moves, but the damage covers its old area.
    send_request(request_of(rect_bits(190, 190, 40, 40), rect_bits(300, 300, 16, 16),
                            1'b0, 1'b0, 64'd0, 32'd0));
    // Motion inside the damage with strips on all four sides.
    send_request(request_of(rect_bits(0, 0, 100, 100), rect_bits(300, 300, 16, 16),
                            1'b0, 1'b1, rect_bits(20, 30, 40, 50), 32'h0005_0007));
    // The longest message: copy, four strips, old area and new cursor.
    send_request(request_of(rect_bits(0, 0, 100, 100), rect_bits(500, 500, 8, 8),
                            1'b0, 1'b1, rect_bits(10, 10, 10, 10), 32'hFFFF_FFFF));
    // Motion that fills the damage: copy rectangle only.
    send_request(request_of(rect_bits(40, 40, 60, 60), rect_bits(500, 500, 8, 8),
                            1'b0, 1'b1, rect_bits(40, 40, 60, 60), 32'h1234_5678));
    // Motion of zero size is still sent as the copy rectangle.
    send_request(request_of(rect_bits(0, 0, 50, 50), rect_bits(500, 500, 8, 8),
                            1'b0, 1'b1, rect_bits(5, 5, 0, 0), 32'h0001_0002));
    // Motion outside the damage: the strip tests run as they are.
    send_request(request_of(rect_bits(100, 100, 20, 20), rect_bits(500, 500, 8, 8),
                            1'b0, 1'b1, rect_bits(10, 10, 5, 5), 32'h0000_0000));
    // Strip edges past the top of the range saturate.
    send_request(request_of(rect_bits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                            rect_bits(500, 500, 8, 8), 1'b0, 1'b1,
                            rect_bits(16'hFFF0, 16'hFFF0, 16'h0100, 16'h0100),
                            32'hABCD_EF01));
    // Motion without damage is ignored.
    send_request(request_of(rect_bits(5, 5, 0, 9), rect_bits(500, 500, 8, 8),
                            1'b0, 1'b1, rect_bits(1, 2, 3, 4), 32'h0003_0004));
    // Every input bit high.
    send_request(request_of({64{1'b1}}, {64{1'b1}}, 1'b1, 1'b1, {64{1'b1}}, 32'hFFFF_FFFF));
    // A cursor of zero size after a large one: only the old area goes out.
    send_request(request_of(64'd0, rect_bits(7, 7, 0, 0), 1'b1, 1'b0, 64'd0, 32'd0));
    // Extreme damage with a full-screen cursor at the origin.
    send_request(request_of(rect_bits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                            rect_bits(0, 0, 16'hFFFF, 16'hFFFF), 1'b0, 1'b0, 64'd0, 32'd0));
    // Tiny damage under the still full-screen cursor.
    send_request(request_of(rect_bits(0, 0, 1, 1), rect_bits(0, 0, 16'hFFFF, 16'hFFFF),
                            1'b0, 1'b0, 64'd0, 32'd0));
  endtask

  task automatic test_random_updates(int count);
    idle_on = 1'b1;
    repeat (count) send_request(random_request(1'b0));
  endtask

  // Both sides run flat out, so requests queue behind draining lists.
  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    repeat (count) send_request(random_request(1'b0));
    idle_on = 1'b1;
  endtask

  task automatic test_noise_fields(int count);
    idle_on = 1'b1;
    repeat (count) send_request(random_request(1'b1));
  endtask

  // ---------------------------------------------------------------------
  // Output side: random stall and the beat checker.
  // ---------------------------------------------------------------------

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= idle_on ? ($urandom_range(99) >= 17) : 1'b1;
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rect_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (planned_beats.size() == 0) begin
        $display("%0t: beat with none expected, expected nothing, actual rect %h",
                 $time, m_tdata[63:0]);
        errors++;
      end else begin
        want = planned_beats.pop_front();
        check_field("rect", want.rect, m_tdata[63:0]);
        check_field("encoding", want.enc, m_tuser[0]);
        check_field("copy_source", want.src, m_tdata[95:64]);
        check_field("rect_kind", want.kind, m_tuser[2:1]);
        check_field("rect_total", want.total, m_tdata[98:96]);
        check_field("last", want.last, m_tlast);
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL framebuffer_update_rect_planner");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------

  initial begin
    errors = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    cursor_seen = 64'd0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_random_updates(50);
    test_back_to_back(30);
    test_noise_fields(30);

    s_tvalid <= 1'b0;
    // Drain what is owed, then give a request that makes no beat time to
    // show that it really makes none.
    while (planned_beats.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS framebuffer_update_rect_planner");
    end else begin
      $display("FAIL framebuffer_update_rect_planner");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/fbur_pkg.sv
src/fbur_plan.sv
src/fbur_queue.sv
src/framebuffer_update_rect_planner.sv
src/fbur_checker.sv
bench/testbench.sv
